// ===== rtl/core/dpmd_pkg.sv =====
package dpmd_pkg;

  // Defaults for the top-level parameters
  localparam int FRAC_BITS_DEF = 8;
  localparam int DIST_MAX_DEF  = 2000;

  // Field widths
  localparam int DIST_W     = 12;  // raw distance, also whole-mm filter part
  localparam int MM_W       = 11;
  localparam int GAIN_W     = 12;
  localparam int LIMIT_W    = 10;
  localparam int PWM_W      = 8;
  localparam int ERR_W      = 13;  // dmm - target, signed
  localparam int PREV_W     = 12;
  localparam int DERIV_W    = 20;  // 50 * (err - prev), signed
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Arithmetic constants
  localparam int ALPHA_NUM   = 77;
  localparam int ALPHA_REST  = 179;
  localparam int ALPHA_SHIFT = 8;
  localparam int GAIN_FRAC   = 8;
  localparam int TICKS       = 50;
  localparam int PREV_MAX    = 2047;

  // Register reset values
  localparam logic [MM_W-1:0]    TARGET_RST  = MM_W'(280);
  localparam logic [MM_W-1:0]    STOP_RST    = MM_W'(200);
  localparam logic [GAIN_W-1:0]  GAIN_P_RST  = GAIN_W'(256);
  localparam logic [GAIN_W-1:0]  GAIN_I_RST  = GAIN_W'(38);
  localparam logic [GAIN_W-1:0]  GAIN_D_RST  = GAIN_W'(26);
  localparam logic [LIMIT_W-1:0] ILIMIT_RST  = LIMIT_W'(500);
  localparam logic [MM_W-1:0]    FAR_TH_RST  = MM_W'(800);
  localparam logic [PWM_W-1:0]   FAR_CAP_RST = PWM_W'(220);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET  = 3'd0,
    REG_STOP    = 3'd1,
    REG_GAIN_P  = 3'd2,
    REG_GAIN_I  = 3'd3,
    REG_GAIN_D  = 3'd4,
    REG_ILIMIT  = 3'd5,
    REG_FAR_TH  = 3'd6,
    REG_FAR_CAP = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic              sample_valid;
    logic [DIST_W-1:0] distance_mm;
  } in_item_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm_duty;
    logic             stop_zone;
    logic [MM_W-1:0]  filtered_mm;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [MM_W-1:0]    target_distance;
    logic [MM_W-1:0]    stop_distance;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] integral_limit;
    logic [MM_W-1:0]    far_threshold;
    logic [PWM_W-1:0]   far_pwm_cap;
  } cfg_regs_t;

  // Microcode
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_PREP = 4'd4;
  localparam logic [STEP_W-1:0] STEP_STOP = 4'd13;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd13;

  typedef enum logic [2:0] {
    A_XQ, A_FILT, A_NUM, A_ERR, A_DERIV, A_INTEG
  } a_sel_t;

  typedef enum logic [2:0] {
    B_ALPHA, B_REST, B_RECIP, B_GP, B_GD, B_GI
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_FILT, WR_PREP, WR_QEST, WR_QFIX, WR_INTEG, WR_STOP
  } wr_t;

  typedef enum logic [1:0] {
    J_NEXT, J_NOSAMPLE, J_STOP, J_END
  } jmp_t;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    acc_op_t           acc_op;
    logic              acc_shl;
    wr_t               wr;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } uc_word_t;

  typedef struct packed {
    logic     load;
    logic     run;
    uc_word_t uc;
  } dp_ctrl_t;

  typedef struct packed {
    logic sample;
    logic stop;
  } dp_status_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // The program. The product is registered in prod, and acc is loaded from prod.
  function automatic uc_word_t uc_rom(input logic [STEP_W-1:0] step);
    uc_word_t w;
    w = '{a_sel: A_XQ, b_sel: B_ALPHA, acc_op: ACC_HOLD, acc_shl: 1'b0,
          wr: WR_NONE, jmp: J_NEXT, target: '0};
    case (step)
      4'd0: begin  // 77 * xq, skip filter when no sample
        w.a_sel = A_XQ;   w.b_sel = B_ALPHA;
        w.jmp   = J_NOSAMPLE; w.target = STEP_PREP;
      end
      4'd1: begin  // 179 * f
        w.a_sel = A_FILT; w.b_sel = B_REST; w.acc_op = ACC_LOAD;
      end
      4'd2: begin
        w.acc_op = ACC_ADD;
      end
      4'd3: begin
        w.wr = WR_FILT;
      end
      4'd4: begin  // error, derivative, dividend; branch on stop zone
        w.wr = WR_PREP; w.jmp = J_STOP; w.target = STEP_STOP;
      end
      4'd5: begin  // dividend * reciprocal of 50
        w.a_sel = A_NUM; w.b_sel = B_RECIP;
      end
      4'd6: begin
        w.acc_op = ACC_LOAD;
      end
      4'd7: begin
        w.wr = WR_QEST; w.a_sel = A_ERR; w.b_sel = B_GP;
      end
      4'd8: begin
        w.wr = WR_QFIX; w.a_sel = A_DERIV; w.b_sel = B_GD;
        w.acc_op = ACC_LOAD; w.acc_shl = 1'b1;
      end
      4'd9: begin
        w.wr = WR_INTEG; w.acc_op = ACC_ADD; w.acc_shl = 1'b1;
      end
      4'd10: begin
        w.a_sel = A_INTEG; w.b_sel = B_GI;
      end
      4'd11: begin
        w.acc_op = ACC_ADD;
      end
      4'd12: begin
        w.jmp = J_END;
      end
      4'd13: begin
        w.wr = WR_STOP; w.jmp = J_END;
      end
      default: begin
        w.jmp = J_END;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/dpmd_stream_if.sv =====
interface dpmd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/dpmd_datapath.sv =====
module dpmd_datapath #(
  parameter int FRAC_BITS = dpmd_pkg::FRAC_BITS_DEF,
  parameter int DIST_MAX  = dpmd_pkg::DIST_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dpmd_pkg::dp_ctrl_t  ctrl,
  input  dpmd_pkg::in_item_t  item,
  input  dpmd_pkg::cfg_regs_t regs,
  output dpmd_pkg::dp_status_t status,
  output dpmd_pkg::out_item_t result
);

  localparam int F       = FRAC_BITS;
  localparam int FILT_W  = dpmd_pkg::DIST_W + F;
  localparam int NUM_W   = dpmd_pkg::DIST_W + 1 + F;
  localparam int A_W     = (NUM_W + 1 > dpmd_pkg::DERIV_W) ? NUM_W + 1 : dpmd_pkg::DERIV_W;
  localparam int RECIP_S = NUM_W + 7;
  localparam int B_W     = RECIP_S - 4;
  localparam int PROD_W  = A_W + B_W;
  localparam int ACC_W   = PROD_W;
  localparam int Q_W     = F + 9;
  localparam int QS_W    = Q_W + 1;
  localparam int INT_W   = dpmd_pkg::LIMIT_W + 1 + F;
  localparam int ISUM_W  = INT_W + 1;
  localparam int HI_W    = ACC_W - dpmd_pkg::GAIN_FRAC - F;
  localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_S) / 64'(dpmd_pkg::TICKS);
  localparam logic [FILT_W-1:0] FILT_RST = FILT_W'(DIST_MAX) << F;
  localparam logic [dpmd_pkg::DIST_W-1:0] DMAX = dpmd_pkg::DIST_W'(DIST_MAX);
  localparam logic signed [dpmd_pkg::ERR_W-1:0] PREV_HI =
    dpmd_pkg::ERR_W'(dpmd_pkg::PREV_MAX);

  logic                                 samp;
  logic [FILT_W-1:0]                    xq;
  logic [FILT_W-1:0]                    filt;
  logic signed [dpmd_pkg::ERR_W-1:0]    err_r;
  logic [NUM_W-1:0]                     num;
  logic                                 neg;
  logic signed [dpmd_pkg::DERIV_W-1:0]  deriv_r;
  logic [Q_W-1:0]                       qest;
  logic signed [QS_W-1:0]               qs;
  logic signed [INT_W-1:0]              integ;
  logic signed [dpmd_pkg::PREV_W-1:0]   prev;
  logic signed [PROD_W-1:0]             prod;
  logic signed [ACC_W-1:0]              acc;

  logic [dpmd_pkg::DIST_W-1:0]          x_sat;
  logic [dpmd_pkg::DIST_W-1:0]          dmm;
  logic signed [dpmd_pkg::ERR_W-1:0]    err_c;
  logic [dpmd_pkg::ERR_W-2:0]           mag_c;
  logic [NUM_W-1:0]                     num_c;
  logic signed [dpmd_pkg::ERR_W:0]      diff;
  logic signed [dpmd_pkg::DERIV_W-1:0]  d20;
  logic signed [dpmd_pkg::DERIV_W-1:0]  deriv_c;
  logic signed [A_W-1:0]                a_op;
  logic signed [B_W-1:0]                b_op;
  logic signed [ACC_W-1:0]              term;
  logic [NUM_W:0]                       q50;
  logic [NUM_W:0]                       rem;
  logic [Q_W-1:0]                       qfix;
  logic signed [ISUM_W-1:0]             isum;
  logic signed [ISUM_W-1:0]             lim;
  logic signed [ISUM_W-1:0]             isum_clamp;
  logic [HI_W-1:0]                      hi;
  logic [dpmd_pkg::PWM_W-1:0]           duty_sat;
  logic [dpmd_pkg::PWM_W-1:0]           duty_c;
  logic                                 far;
  logic                                 stop_c;

  assign x_sat  = (item.distance_mm > DMAX) ? DMAX : item.distance_mm;
  assign dmm    = filt[FILT_W-1:F];
  assign stop_c = dmm < {1'b0, regs.stop_distance};
  assign err_c  = $signed({1'b0, dmm}) - $signed({2'b00, regs.target_distance});

  // |err| * 2^F, plus 49 when negative so a floor quotient comes out of n / 50
  assign mag_c = err_c[dpmd_pkg::ERR_W-1] ? (dpmd_pkg::ERR_W-1)'(-err_c)
                                          : err_c[dpmd_pkg::ERR_W-2:0];
  assign num_c = {1'b0, mag_c, {F{1'b0}}} +
                 (err_c[dpmd_pkg::ERR_W-1] ? NUM_W'(dpmd_pkg::TICKS - 1) : NUM_W'(0));

  assign diff    = $signed({err_c[dpmd_pkg::ERR_W-1], err_c}) -
                   $signed({{2{prev[dpmd_pkg::PREV_W-1]}}, prev});
  assign d20     = dpmd_pkg::DERIV_W'(diff);
  assign deriv_c = (d20 <<< 5) + (d20 <<< 4) + (d20 <<< 1);

  always_comb begin
    case (ctrl.uc.a_sel)
      dpmd_pkg::A_XQ:    a_op = $signed({{(A_W-FILT_W){1'b0}}, xq});
      dpmd_pkg::A_FILT:  a_op = $signed({{(A_W-FILT_W){1'b0}}, filt});
      dpmd_pkg::A_NUM:   a_op = $signed({{(A_W-NUM_W){1'b0}}, num});
      dpmd_pkg::A_ERR:   a_op = A_W'(err_r);
      dpmd_pkg::A_DERIV: a_op = A_W'(deriv_r);
      dpmd_pkg::A_INTEG: a_op = A_W'(integ);
      default:           a_op = '0;
    endcase
    case (ctrl.uc.b_sel)
      dpmd_pkg::B_ALPHA: b_op = B_W'(dpmd_pkg::ALPHA_NUM);
      dpmd_pkg::B_REST:  b_op = B_W'(dpmd_pkg::ALPHA_REST);
      dpmd_pkg::B_RECIP: b_op = $signed(B_W'(RECIP_FULL));
      dpmd_pkg::B_GP:    b_op = $signed({{(B_W-dpmd_pkg::GAIN_W){1'b0}}, regs.gain_p});
      dpmd_pkg::B_GD:    b_op = $signed({{(B_W-dpmd_pkg::GAIN_W){1'b0}}, regs.gain_d});
      dpmd_pkg::B_GI:    b_op = $signed({{(B_W-dpmd_pkg::GAIN_W){1'b0}}, regs.gain_i});
      default:           b_op = '0;
    endcase
  end

  assign term = ctrl.uc.acc_shl ? (prod <<< F) : prod;

  // Quotient estimate is low by at most one
  assign q50  = (NUM_W+1)'({qest, 5'b0}) + (NUM_W+1)'({qest, 4'b0}) +
                (NUM_W+1)'({qest, 1'b0});
  assign rem  = {1'b0, num} - q50;
  assign qfix = (rem >= (NUM_W+1)'(dpmd_pkg::TICKS)) ? qest + 1'b1 : qest;

  assign lim  = $signed({{(ISUM_W-dpmd_pkg::LIMIT_W-F){1'b0}}, regs.integral_limit,
                         {F{1'b0}}});
  assign isum = ISUM_W'(integ) + ISUM_W'(qs);
  always_comb begin
    if (isum > lim) begin
      isum_clamp = lim;
    end else if (isum < -lim) begin
      isum_clamp = -lim;
    end else begin
      isum_clamp = isum;
    end
  end

  // Duty: integer part of acc / 2^(8+F), zero when acc <= 0, capped at 255 and at the far cap when far
  assign hi       = acc[ACC_W-1:dpmd_pkg::GAIN_FRAC+F];
  assign duty_sat = (|hi[HI_W-1:dpmd_pkg::PWM_W]) ? '1 : hi[dpmd_pkg::PWM_W-1:0];
  assign far      = dmm > {1'b0, regs.far_threshold};
  always_comb begin
    if (acc[ACC_W-1] || (acc == '0)) begin
      duty_c = '0;
    end else begin
      duty_c = duty_sat;
    end
    if (far && (duty_c > regs.far_pwm_cap)) begin
      duty_c = regs.far_pwm_cap;
    end
  end

  assign status.sample = samp;
  assign status.stop   = stop_c;

  assign result.pwm_duty    = stop_c ? '0 : duty_c;
  assign result.stop_zone   = stop_c;
  assign result.filtered_mm = dmm[dpmd_pkg::DIST_W-1] ? '1 : dmm[dpmd_pkg::MM_W-1:0];

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      filt  <= FILT_RST;
      integ <= '0;
      prev  <= '0;
    end else if (ctrl.run) begin
      case (ctrl.uc.wr)
        dpmd_pkg::WR_FILT:  filt <= acc[dpmd_pkg::ALPHA_SHIFT +: FILT_W];
        dpmd_pkg::WR_INTEG: begin
          integ <= INT_W'(isum_clamp);
          prev  <= (err_r > PREV_HI) ? dpmd_pkg::PREV_W'(dpmd_pkg::PREV_MAX)
                                     : err_r[dpmd_pkg::PREV_W-1:0];
        end
        dpmd_pkg::WR_STOP:  integ <= '0;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      samp <= item.sample_valid;
      xq   <= {x_sat, {F{1'b0}}};
    end
    if (ctrl.run) begin
      prod <= a_op * b_op;
      case (ctrl.uc.acc_op)
        dpmd_pkg::ACC_LOAD: acc <= term;
        dpmd_pkg::ACC_ADD:  acc <= acc + term;
        default: ;
      endcase
      case (ctrl.uc.wr)
        dpmd_pkg::WR_PREP: begin
          err_r   <= err_c;
          num     <= num_c;
          neg     <= err_c[dpmd_pkg::ERR_W-1];
          deriv_r <= deriv_c;
        end
        dpmd_pkg::WR_QEST: qest <= acc[RECIP_S +: Q_W];
        dpmd_pkg::WR_QFIX: qs   <= neg ? -$signed({1'b0, qfix}) : $signed({1'b0, qfix});
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/distance_pid_motor_drive_top.sv =====
// Flow: a tick is taken only while idle, so the next waits until the last
//   result is loaded; a tick without a sample skips the filter steps, one in the stop zone ends at the stop step.
//   The pace is set by the one shared multiplier and accumulator that the
//   microcode steps through.
// Reset (rst, synchronous): registers to their defaults, filter to DIST_MAX,
//   integral and previous error to zero, sequencer idle, no result pending.
module distance_pid_motor_drive_top #(
  parameter int FRAC_BITS = dpmd_pkg::FRAC_BITS_DEF,
  parameter int DIST_MAX  = dpmd_pkg::DIST_MAX_DEF
) (
  input logic            clk,
  input logic            rst,
  dpmd_stream_if.sink    tick,   // in_item_t beats
  dpmd_stream_if.source  drive,  // out_item_t beats
  dpmd_stream_if.sink    cfg     // cfg_item_t beats
);

  // ---------------------------------------------------------------------
  // Configuration registers. Always ready; to be written only while idle, which the block does not enforce.
  // ---------------------------------------------------------------------
  dpmd_pkg::cfg_regs_t regs;
  dpmd_pkg::cfg_item_t cfg_beat;

  assign cfg.ready = 1'b1;
  assign cfg_beat  = cfg.payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.target_distance <= dpmd_pkg::TARGET_RST;
      regs.stop_distance   <= dpmd_pkg::STOP_RST;
      regs.gain_p          <= dpmd_pkg::GAIN_P_RST;
      regs.gain_i          <= dpmd_pkg::GAIN_I_RST;
      regs.gain_d          <= dpmd_pkg::GAIN_D_RST;
      regs.integral_limit  <= dpmd_pkg::ILIMIT_RST;
      regs.far_threshold   <= dpmd_pkg::FAR_TH_RST;
      regs.far_pwm_cap     <= dpmd_pkg::FAR_CAP_RST;
    end else if (cfg.valid) begin
      case (dpmd_pkg::cfg_reg_t'(cfg_beat.index))
        dpmd_pkg::REG_TARGET:  regs.target_distance <= cfg_beat.data[dpmd_pkg::MM_W-1:0];
        dpmd_pkg::REG_STOP:    regs.stop_distance   <= cfg_beat.data[dpmd_pkg::MM_W-1:0];
        dpmd_pkg::REG_GAIN_P:  regs.gain_p          <= cfg_beat.data;
        dpmd_pkg::REG_GAIN_I:  regs.gain_i          <= cfg_beat.data;
        dpmd_pkg::REG_GAIN_D:  regs.gain_d          <= cfg_beat.data;
        dpmd_pkg::REG_ILIMIT:  regs.integral_limit  <= cfg_beat.data[dpmd_pkg::LIMIT_W-1:0];
        dpmd_pkg::REG_FAR_TH:  regs.far_threshold   <= cfg_beat.data[dpmd_pkg::MM_W-1:0];
        dpmd_pkg::REG_FAR_CAP: regs.far_pwm_cap     <= cfg_beat.data[dpmd_pkg::PWM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Microcode sequencer. The step counter addresses the control ROM; each
  // control word picks multiplier operands, an accumulator action, one
  // register writeback and a jump. The last step parks until the output
  // register is free, so a waiting result never loses a beat.
  // ---------------------------------------------------------------------
  dpmd_pkg::seq_state_t          state;
  dpmd_pkg::seq_state_t          state_next;
  logic [dpmd_pkg::STEP_W-1:0]   step;
  logic [dpmd_pkg::STEP_W-1:0]   step_next;
  dpmd_pkg::uc_word_t            uc;
  dpmd_pkg::dp_ctrl_t            ctrl;
  dpmd_pkg::dp_status_t          status;
  dpmd_pkg::out_item_t           result;
  logic                          tick_beat;
  logic                          stall;
  logic                          run;

  assign uc        = dpmd_pkg::uc_rom(step);
  assign tick.ready = (state == dpmd_pkg::SEQ_IDLE);
  assign tick_beat = tick.valid && tick.ready;
  // Hold on the final step while the previous result is still unclaimed
  assign stall     = (uc.jmp == dpmd_pkg::J_END) && drive.valid && !drive.ready;
  assign run       = (state == dpmd_pkg::SEQ_RUN) && !stall;

  assign ctrl.load = tick_beat;
  assign ctrl.run  = run;
  assign ctrl.uc   = uc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpmd_pkg::SEQ_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      dpmd_pkg::SEQ_IDLE: begin
        if (tick_beat) begin
          state_next = dpmd_pkg::SEQ_RUN;
          step_next  = '0;
        end
      end
      dpmd_pkg::SEQ_RUN: begin
        if (run) begin
          case (uc.jmp)
            dpmd_pkg::J_NEXT:     step_next = step + 1'b1;
            dpmd_pkg::J_NOSAMPLE: step_next = status.sample ? step + 1'b1 : uc.target;
            dpmd_pkg::J_STOP:     step_next = status.stop ? uc.target : step + 1'b1;
            dpmd_pkg::J_END:      state_next = dpmd_pkg::SEQ_IDLE;
            default:              state_next = dpmd_pkg::SEQ_IDLE;
          endcase
        end
      end
      default: state_next = dpmd_pkg::SEQ_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath: filter, PID terms, integral clamp and duty shaping
  // ---------------------------------------------------------------------
  dpmd_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .DIST_MAX  (DIST_MAX)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .item   (tick.payload),
    .regs   (regs),
    .status (status),
    .result (result)
  );

  // ---------------------------------------------------------------------
  // Output register: loaded on the final step, freed by the ready side
  // ---------------------------------------------------------------------
  logic                out_valid;
  dpmd_pkg::out_item_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run && (uc.jmp == dpmd_pkg::J_END)) begin
      out_valid <= 1'b1;
    end else if (drive.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run && (uc.jmp == dpmd_pkg::J_END)) begin
      out_data <= result;
    end
  end

  assign drive.valid   = out_valid;
  assign drive.payload = out_data;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_start_at_zero: assert property (@(posedge clk) disable iff (rst)
    tick_beat |=> (state == dpmd_pkg::SEQ_RUN) && (step == '0))
    else $error("sequencer did not start at step zero");

  a_step_in_program: assert property (@(posedge clk) disable iff (rst)
    (state == dpmd_pkg::SEQ_RUN) |-> (step <= dpmd_pkg::STEP_LAST))
    else $error("step counter left the program");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(drive.valid) |-> $past(state == dpmd_pkg::SEQ_RUN))
    else $error("result appeared without a running tick");

  a_stop_means_idle_motor: assert property (@(posedge clk) disable iff (rst)
    (drive.valid && drive.payload.stop_zone) |-> (drive.payload.pwm_duty == '0))
    else $error("motor driven inside the stop zone");

endmodule
